// ===== sv/tce_pkg.sv =====
// Package for the text console engine: shared types, codes and constants.
`timescale 1ns / 1ps
`default_nettype none

package tce_pkg;

    // Request and response payloads, fields in the order of the interface spec.
    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
        logic [4:0]  new_row;
        logic [6:0]  new_col;
    } req_t;

    typedef struct packed {
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
        logic [4:0] cursor_row;
        logic [6:0] cursor_col;
    } rsp_t;

    // Request opcodes.
    localparam logic [1:0] OP_PUT    = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_SETCUR = 2'd2;

    // Character codes the console interprets.
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_TAB       = 8'd9;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_VTAB      = 8'd11;
    localparam logic [7:0] CH_FORMFEED  = 8'd12;
    localparam logic [7:0] CH_RETURN    = 8'd13;
    localparam logic [7:0] CH_PRINT_LO  = 8'd32;
    localparam logic [7:0] CH_PRINT_HI  = 8'd126;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] TAB_STEP     = 8'd8;

    // A cell is {attribute, character}.
    localparam int unsigned CELL_W      = 16;
    localparam logic [7:0]  BLANK_ATTR  = 8'h0F;
    localparam logic [15:0] BLANK_CELL  = {BLANK_ATTR, CH_SPACE};

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W    = 1;
    localparam logic [0:0]  CFG_TEXT_COLOR = 1'b0;
    localparam logic [0:0]  CFG_BACK_COLOR = 1'b1;
    localparam logic [3:0]  TEXT_COLOR_RESET = 4'hF;
    localparam logic [3:0]  BACK_COLOR_RESET = 4'h0;

    // Depth of the command queue between front and back (power of two).
    localparam int unsigned QUEUE_DEPTH = 2;

    // Classified command.
    typedef enum logic [3:0] {
        K_NOP,
        K_PRINT,
        K_NEWLINE,
        K_TAB,
        K_BACKSPACE,
        K_RETURN,
        K_VTAB,
        K_FORMFEED,
        K_READ,
        K_SETCUR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
        logic [4:0]  row;
        logic [6:0]  col;
    } cmd_t;

    // Front to queue.
    typedef struct packed {
        logic push;
        cmd_t cmd;
    } front_push_t;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_NL_WRITE,
        ST_FILL,
        ST_SCROLL,
        ST_RESULT
    } state_t;

endpackage

`default_nettype wire

// ===== sv/tce_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module tce_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/tce_front.sv =====
// Front end: accept requests, classify them into commands, saturate operands.
`timescale 1ns / 1ps
`default_nettype none

module tce_front #(
    parameter int unsigned COLUMNS = 80,
    parameter int unsigned ROWS    = 25
) (
    input  wire logic                 req_valid,
    output logic                      req_stall,
    input  wire tce_pkg::req_t        req,
    input  wire logic                 queue_full,
    input  wire logic                 init_busy,
    output tce_pkg::front_push_t      fpush
);

    localparam int unsigned CELLS = COLUMNS * ROWS;

    tce_pkg::cmd_kind_t kind;
    logic               printable;
    logic               read_ok;

    assign req_stall = queue_full || init_busy;
    assign printable = (req.char_code >= tce_pkg::CH_PRINT_LO)
                    && (req.char_code <= tce_pkg::CH_PRINT_HI);
    assign read_ok   = {2'b00, req.cell_index} < 13'(CELLS);

    always_comb
    begin
        kind = tce_pkg::K_NOP;
        unique case (req.op)
            tce_pkg::OP_PUT:
            begin
                if (printable)
                begin
                    kind = tce_pkg::K_PRINT;
                end
                else
                begin
                    unique case (req.char_code)
                        tce_pkg::CH_NEWLINE:   kind = tce_pkg::K_NEWLINE;
                        tce_pkg::CH_TAB:       kind = tce_pkg::K_TAB;
                        tce_pkg::CH_BACKSPACE: kind = tce_pkg::K_BACKSPACE;
                        tce_pkg::CH_FORMFEED:  kind = tce_pkg::K_FORMFEED;
                        tce_pkg::CH_RETURN:    kind = tce_pkg::K_RETURN;
                        tce_pkg::CH_VTAB:      kind = tce_pkg::K_VTAB;
                        default:               kind = tce_pkg::K_NOP;
                    endcase
                end
            end
            // out-of-range reads answer zero, like a no-op
            tce_pkg::OP_READ:   kind = read_ok ? tce_pkg::K_READ : tce_pkg::K_NOP;
            tce_pkg::OP_SETCUR: kind = tce_pkg::K_SETCUR;
            default:            kind = tce_pkg::K_NOP;
        endcase
    end

    always_comb
    begin
        fpush.push           = req_valid && !req_stall;
        fpush.cmd.kind       = kind;
        fpush.cmd.char_code  = req.char_code;
        fpush.cmd.cell_index = req.cell_index;
        fpush.cmd.row        = ({1'b0, req.new_row} < 6'(ROWS))
                             ? req.new_row : 5'(ROWS - 1);
        fpush.cmd.col        = ({1'b0, req.new_col} < 8'(COLUMNS))
                             ? req.new_col : 7'(COLUMNS - 1);
    end

endmodule

`default_nettype wire

// ===== sv/tce_queue.sv =====
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module tce_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire tce_pkg::front_push_t fpush,
    output logic                      full,
    input  wire logic                 pop,
    output tce_pkg::cmd_t             head,
    output logic                      head_valid
);

    localparam int unsigned PTR_W = $clog2(tce_pkg::QUEUE_DEPTH);

    tce_pkg::cmd_t    entry_reg [tce_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             do_pop;

    assign full       = count_reg == (PTR_W + 1)'(tce_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = fpush.push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        case ({fpush.push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fpush.push)
        begin
            entry_reg[wr_ptr_reg] <= fpush.cmd;
        end
    end

endmodule

`default_nettype wire

// ===== sv/tce_back.sv =====
// Back end: cursor state, screen store sequencing and the response register.
`timescale 1ns / 1ps
`default_nettype none

module tce_back #(
    parameter int unsigned COLUMNS = 80,
    parameter int unsigned ROWS    = 25
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire tce_pkg::cmd_t   head,
    input  wire logic            head_valid,
    output logic                 pop,
    input  wire logic [7:0]      attr,
    output logic                 init_busy,
    output logic                 rsp_valid,
    input  wire logic            rsp_stall,
    output tce_pkg::rsp_t        rsp
);

    localparam int unsigned CELLS  = COLUMNS * ROWS;
    localparam int unsigned ADDR_W = $clog2(CELLS);
    localparam int unsigned SCAN_W = $clog2(CELLS + COLUMNS);

    tce_pkg::state_t  state_reg, state_next;
    tce_pkg::cmd_t    cmd_reg, cmd_next;
    logic [4:0]       row_reg, row_next;
    logic [6:0]       col_reg, col_next;
    logic [SCAN_W-1:0] scan_reg, scan_next;
    logic             scroll_reg, scroll_next;
    logic             hit_reg, hit_next;
    logic [ADDR_W-1:0] cell_addr_reg, cell_addr_next;
    logic             pend_valid_reg, pend_valid_next;
    logic             pend_blank_reg, pend_blank_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic             rsp_valid_reg, rsp_valid_next;
    tce_pkg::rsp_t    rsp_reg, rsp_next;

    logic [ADDR_W-1:0] cur_addr;
    logic [7:0]        col_step, col_fix;
    logic [5:0]        row_step, row_fix;
    logic              scroll_now;
    logic [4:0]        row_final;
    logic              rsp_free;
    logic              scan_last_cell;
    logic              scan_last_scroll;
    logic              rsp_load;

    logic                       ram_we;
    logic [ADDR_W-1:0]          ram_waddr;
    logic [tce_pkg::CELL_W-1:0] ram_wdata;
    logic                       ram_re;
    logic [ADDR_W-1:0]          ram_raddr;
    logic [tce_pkg::CELL_W-1:0] ram_rdata;

    tce_ram #(
        .WIDTH (tce_pkg::CELL_W),
        .DEPTH (CELLS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cur_addr  = ADDR_W'(row_reg) * ADDR_W'(COLUMNS) + ADDR_W'(col_reg);
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign init_busy = state_reg == tce_pkg::ST_INIT;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign scan_last_cell   = scan_reg == SCAN_W'(CELLS - 1);
    assign scan_last_scroll = scan_reg == SCAN_W'(CELLS + COLUMNS - 1);

    // Cursor motion for the command in hand, then wrap and scroll.
    always_comb
    begin
        col_step = {1'b0, col_reg};
        row_step = {1'b0, row_reg};
        unique case (cmd_reg.kind)
            tce_pkg::K_PRINT:     col_step = {1'b0, col_reg} + 8'd1;
            tce_pkg::K_NEWLINE:
            begin
                col_step = '0;
                row_step = {1'b0, row_reg} + 6'd1;
            end
            tce_pkg::K_TAB:       col_step = {1'b0, col_reg} + tce_pkg::TAB_STEP;
            tce_pkg::K_BACKSPACE:
            begin
                if (col_reg != '0)
                begin
                    col_step = {1'b0, col_reg} - 8'd1;
                end
            end
            tce_pkg::K_RETURN:    col_step = '0;
            tce_pkg::K_VTAB:      row_step = {1'b0, row_reg} + 6'd1;
            tce_pkg::K_SETCUR:
            begin
                col_step = {1'b0, cmd_reg.col};
                row_step = {1'b0, cmd_reg.row};
            end
            default:
            begin
                col_step = {1'b0, col_reg};
            end
        endcase

        if (col_step >= 8'(COLUMNS))
        begin
            col_fix = '0;
            row_fix = row_step + 6'd1;
        end
        else
        begin
            col_fix = col_step;
            row_fix = row_step;
        end

        scroll_now = row_fix >= 6'(ROWS);
        row_final  = scroll_now ? 5'(ROWS - 1) : row_fix[4:0];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tce_pkg::ST_INIT:
            begin
                if (scan_last_cell)
                begin
                    state_next = tce_pkg::ST_IDLE;
                end
            end
            tce_pkg::ST_IDLE:
            begin
                if (head_valid)
                begin
                    state_next = tce_pkg::ST_EXEC;
                end
            end
            tce_pkg::ST_EXEC:
            begin
                unique case (cmd_reg.kind)
                    tce_pkg::K_NEWLINE:  state_next = tce_pkg::ST_NL_WRITE;
                    tce_pkg::K_FORMFEED: state_next = tce_pkg::ST_FILL;
                    default:
                    begin
                        state_next = scroll_now ? tce_pkg::ST_SCROLL : tce_pkg::ST_RESULT;
                    end
                endcase
            end
            tce_pkg::ST_NL_WRITE:
            begin
                state_next = scroll_reg ? tce_pkg::ST_SCROLL : tce_pkg::ST_RESULT;
            end
            tce_pkg::ST_FILL:
            begin
                if (scan_last_cell)
                begin
                    state_next = tce_pkg::ST_RESULT;
                end
            end
            tce_pkg::ST_SCROLL:
            begin
                if (scan_last_scroll)
                begin
                    state_next = tce_pkg::ST_RESULT;
                end
            end
            tce_pkg::ST_RESULT:
            begin
                if (rsp_free)
                begin
                    state_next = tce_pkg::ST_IDLE;
                end
            end
            default: state_next = tce_pkg::ST_IDLE;
        endcase
    end

    // Store port, queue pop and response load per state.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cur_addr;
        ram_wdata = tce_pkg::BLANK_CELL;
        ram_re    = 1'b0;
        ram_raddr = cur_addr;
        pop       = 1'b0;
        rsp_load  = 1'b0;

        // a row-copy write comes in the cycle after its read
        if (pend_valid_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = pend_addr_reg;
            ram_wdata = pend_blank_reg ? tce_pkg::BLANK_CELL : ram_rdata;
        end

        unique case (state_reg) inside
            tce_pkg::ST_INIT, tce_pkg::ST_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = scan_reg[ADDR_W-1:0];
                ram_wdata = tce_pkg::BLANK_CELL;
            end
            tce_pkg::ST_IDLE:
            begin
                pop = head_valid;
            end
            tce_pkg::ST_EXEC:
            begin
                unique case (cmd_reg.kind)
                    tce_pkg::K_PRINT:
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = cur_addr;
                        ram_wdata = {attr, cmd_reg.char_code};
                    end
                    tce_pkg::K_NEWLINE:
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = cur_addr;
                    end
                    tce_pkg::K_READ:
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = ADDR_W'(cmd_reg.cell_index);
                    end
                    default:
                    begin
                        ram_re = 1'b0;
                    end
                endcase
            end
            tce_pkg::ST_NL_WRITE:
            begin
                ram_we    = 1'b1;
                ram_waddr = cell_addr_reg;
                ram_wdata = {ram_rdata[15:8], tce_pkg::CH_SPACE};
            end
            tce_pkg::ST_SCROLL:
            begin
                ram_re    = scan_reg < SCAN_W'(CELLS);
                ram_raddr = scan_reg[ADDR_W-1:0];
            end
            tce_pkg::ST_RESULT:
            begin
                rsp_load = rsp_free;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        cmd_next        = cmd_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        scan_next       = scan_reg;
        scroll_next     = scroll_reg;
        hit_next        = hit_reg;
        cell_addr_next  = cell_addr_reg;
        pend_valid_next = 1'b0;
        pend_blank_next = pend_blank_reg;
        pend_addr_next  = pend_addr_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_next        = rsp_reg;

        case (state_reg) inside
            tce_pkg::ST_INIT, tce_pkg::ST_FILL:
            begin
                scan_next = scan_reg + 1'b1;
            end
            tce_pkg::ST_IDLE:
            begin
                if (head_valid)
                begin
                    cmd_next = head;
                end
            end
            tce_pkg::ST_EXEC:
            begin
                row_next       = row_final;
                col_next       = col_fix[6:0];
                scroll_next    = scroll_now;
                cell_addr_next = cur_addr;
                hit_next       = cmd_reg.kind == tce_pkg::K_READ;
                scan_next      = (cmd_reg.kind == tce_pkg::K_FORMFEED)
                               ? '0 : SCAN_W'(2 * COLUMNS);
            end
            tce_pkg::ST_SCROLL:
            begin
                // copy row r+1 into row r; past the end, blank the last row
                scan_next       = scan_reg + 1'b1;
                pend_valid_next = 1'b1;
                pend_addr_next  = ADDR_W'(scan_reg - SCAN_W'(COLUMNS));
                pend_blank_next = scan_reg >= SCAN_W'(CELLS);
            end
            default:
            begin
                scan_next = scan_reg;
            end
        endcase

        if (rsp_load)
        begin
            rsp_valid_next      = 1'b1;
            rsp_next.cell_char  = hit_reg ? ram_rdata[7:0] : 8'd0;
            rsp_next.cell_attr  = hit_reg ? ram_rdata[15:8] : 8'd0;
            rsp_next.cursor_row = row_reg;
            rsp_next.cursor_col = col_reg;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tce_pkg::ST_INIT;
            row_reg        <= 5'd1;
            col_reg        <= '0;
            scan_reg       <= '0;
            scroll_reg     <= 1'b0;
            hit_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            scan_reg       <= scan_next;
            scroll_reg     <= scroll_next;
            hit_reg        <= hit_next;
            pend_valid_reg <= pend_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        cell_addr_reg  <= cell_addr_next;
        pend_blank_reg <= pend_blank_next;
        pend_addr_reg  <= pend_addr_next;
        rsp_reg        <= rsp_next;
    end

endmodule

`default_nettype wire

// ===== sv/text_console_engine.sv =====
// Top level of the text console engine: config registers, front, queue, back.
//
// Text console over a COLUMNS x ROWS store of 16-bit cells ({attribute,
// character}). Each request gives exactly one response carrying the cursor
// after the request and, for a cell read, that cell. The front end classifies
// a request in the cycle it is taken and drops it into a two-entry command
// queue, so requests keep flowing while the back end is busy or a response
// waits, until the queue is full. The back end handles one command at a
// time against a single store with one write and one registered read
// port: printable characters, cursor moves, reads and set-cursor go
// through pop, execute and respond, and a newline adds a read-modify-write
// of the cursor cell. A form feed sweeps all COLUMNS*ROWS cells of the
// store one cell per cycle. A scroll copies rows 2..ROWS-1 up and blanks
// the last row at one cell per cycle. After reset the store is blanked by
// the same sweep, during which req_stall is held high; config writes are
// taken at any time (cfg_ready is always high) and should only be issued
// while the console is idle.
// Row 0 is a status row and never scrolls. Reset puts the cursor at row 1.
`timescale 1ns / 1ps
`default_nettype none

module text_console_engine #(
    parameter int unsigned COLUMNS = 80,
    parameter int unsigned ROWS    = 25
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // request channel
    input  wire logic                            req_valid,
    output logic                                 req_stall,
    input  wire tce_pkg::req_t                   req,
    // response channel
    output logic                                 rsp_valid,
    input  wire logic                            rsp_stall,
    output tce_pkg::rsp_t                        rsp,
    // configuration write channel
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [tce_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [3:0]                      cfg_data
);

    logic [3:0] text_color_reg, text_color_next;
    logic [3:0] back_color_reg, back_color_next;
    logic [7:0] attr;

    tce_pkg::front_push_t fpush;
    tce_pkg::cmd_t        head;
    logic                 head_valid;
    logic                 queue_full;
    logic                 pop;
    logic                 init_busy;

    // Config writes land in the color registers; the port never pushes back.
    assign cfg_ready = 1'b1;
    assign attr      = {back_color_reg, text_color_reg};

    always_comb
    begin
        text_color_next = text_color_reg;
        back_color_next = back_color_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tce_pkg::CFG_TEXT_COLOR: text_color_next = cfg_data;
                tce_pkg::CFG_BACK_COLOR: back_color_next = cfg_data;
                default:                 text_color_next = text_color_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg <= tce_pkg::TEXT_COLOR_RESET;
            back_color_reg <= tce_pkg::BACK_COLOR_RESET;
        end
        else
        begin
            text_color_reg <= text_color_next;
            back_color_reg <= back_color_next;
        end
    end

    // Classify and saturate incoming requests; hold them off while the
    // queue is full or the store is still being blanked after reset.
    tce_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .queue_full (queue_full),
        .init_busy  (init_busy),
        .fpush      (fpush)
    );

    // Decouple the front from the long-running back-end operations.
    tce_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .fpush      (fpush),
        .full       (queue_full),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    // Execute commands against the store and hold the response.
    tce_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .attr       (attr),
        .init_busy  (init_busy),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp)
    );

endmodule

`default_nettype wire

// ===== sv/tce_checker.sv =====
// Port-level checker for the text console engine and its bind statement.
`timescale 1ns / 1ps
`default_nettype none

module tce_checker #(
    parameter int unsigned COLUMNS = 80,
    parameter int unsigned ROWS    = 25
) (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            req_valid,
    input wire logic                            req_stall,
    input wire tce_pkg::req_t                   req,
    input wire logic                            rsp_valid,
    input wire logic                            rsp_stall,
    input wire tce_pkg::rsp_t                   rsp,
    input wire logic                            cfg_valid,
    input wire logic                            cfg_ready
);

    logic [3:0] outstanding_reg, outstanding_next;
    logic       req_take;
    logic       rsp_take;

    assign req_take = req_valid && !req_stall;
    assign rsp_take = rsp_valid && !rsp_stall;

    always_comb
    begin
        outstanding_next = outstanding_reg;
        case ({req_take, rsp_take})
            2'b10:   outstanding_next = outstanding_reg + 4'd1;
            2'b01:   outstanding_next = outstanding_reg - 4'd1;
            default: outstanding_next = outstanding_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
        end
    end

    // A waiting response holds still.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // The reported cursor always lies on the screen.
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ({1'b0, rsp.cursor_row} < 6'(ROWS))
                   && ({1'b0, rsp.cursor_col} < 8'(COLUMNS)))
        else $error("cursor outside the screen");

    // No response without a request still owed one.
    a_no_extra_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> outstanding_reg != '0)
        else $error("response without a pending request");

    // Requests are held off as reset is released, while the store is blanked.
    a_init_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> req_stall)
        else $error("request taken before the store was blanked");

    // The register port never pushes back.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write held off");

endmodule

bind text_console_engine tce_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tce_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

`default_nettype wire

// ===== dv/text_console_engine_checker.sv =====
// Checker for the text console engine: screen predictor and response comparison.
`timescale 1ns / 1ps

module text_console_engine_checker #(
    parameter int unsigned COLUMNS = 80,
    parameter int unsigned ROWS    = 25
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    input  logic                                req_stall,
    input  tce_pkg::req_t                       req,
    input  logic                                rsp_valid,
    input  logic                                rsp_stall,
    input  tce_pkg::rsp_t                       rsp,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [tce_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [3:0]                          cfg_data,
    output int                                  fail_count,
    output int                                  pending
);
    import tce_pkg::*;

    localparam int unsigned CELLS = COLUMNS * ROWS;

    // Model of the screen, cursor and colors, {attribute, character} per cell.
    logic [15:0]  screen [CELLS];
    int unsigned  row_now;
    int unsigned  col_now;
    logic [3:0]   fg_color;
    logic [3:0]   paper_color;
    rsp_t         due_status_q [$];

    function automatic void blank_screen();
        for (int i = 0; i < CELLS; i++)
            screen[i] = BLANK_CELL;
    endfunction

    // Apply one request to the model and return the response it must produce.
    function automatic rsp_t advance_console(req_t r);
        rsp_t        o;
        int unsigned at;
        o = '0;
        case (r.op)
            OP_PUT:
            begin
                at = row_now * COLUMNS + col_now;
                if (r.char_code >= CH_PRINT_LO && r.char_code <= CH_PRINT_HI)
                begin
                    screen[at] = {paper_color, fg_color, r.char_code};
                    col_now++;
                end
                else
                begin
                    case (r.char_code)
                        CH_NEWLINE:
                        begin
                            // blank the character only, attribute stays
                            screen[at][7:0] = CH_SPACE;
                            col_now = 0;
                            row_now++;
                        end
                        CH_TAB:       col_now += TAB_STEP;
                        CH_BACKSPACE: if (col_now > 0) col_now--;
                        CH_FORMFEED:  blank_screen();
                        CH_RETURN:    col_now = 0;
                        CH_VTAB:      row_now++;
                        default:      ;
                    endcase
                end
                if (col_now >= COLUMNS)
                begin
                    col_now = 0;
                    row_now++;
                end
                if (row_now >= ROWS)
                begin
                    // status row 0 stays; rows 2.. shift up, last row blanks
                    for (int i = COLUMNS; i < COLUMNS * (ROWS - 1); i++)
                        screen[i] = screen[i + COLUMNS];
                    for (int i = COLUMNS * (ROWS - 1); i < CELLS; i++)
                        screen[i] = BLANK_CELL;
                    row_now = ROWS - 1;
                end
            end
            OP_READ:
            begin
                if (r.cell_index < CELLS)
                    {o.cell_attr, o.cell_char} = screen[r.cell_index];
            end
            OP_SETCUR:
            begin
                row_now = (r.new_row < ROWS) ? r.new_row : ROWS - 1;
                col_now = (r.new_col < COLUMNS) ? r.new_col : COLUMNS - 1;
            end
            default: ;
        endcase
        o.cursor_row = 5'(row_now);
        o.cursor_col = 7'(col_now);
        return o;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            blank_screen();
            row_now     = 1;
            col_now     = 0;
            fg_color    = TEXT_COLOR_RESET;
            paper_color = BACK_COLOR_RESET;
            due_status_q.delete();
        end
        else
        begin
            // retire the response first: a request taken this edge cannot answer yet
            if (rsp_valid && !rsp_stall)
            begin
                if (due_status_q.size() == 0)
                begin
                    $display("%0t: response with nothing outstanding, actual %p", $time, rsp);
                    fail_count++;
                end
                else
                begin
                    want = due_status_q.pop_front();
                    check_field("cell_char", want.cell_char, rsp.cell_char);
                    check_field("cell_attr", want.cell_attr, rsp.cell_attr);
                    check_field("cursor_row", want.cursor_row, rsp.cursor_row);
                    check_field("cursor_col", want.cursor_col, rsp.cursor_col);
                end
            end
            if (req_valid && !req_stall)
                due_status_q.push_back(advance_console(req));
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_TEXT_COLOR)
                    fg_color = cfg_data;
                else if (cfg_index == CFG_BACK_COLOR)
                    paper_color = cfg_data;
            end
        end
        pending = due_status_q.size();
    end

endmodule

// ===== dv/tb_text_console_engine.sv =====
// Testbench top for the text console engine: stimulus, idling and the verdict.
`timescale 1ns / 1ps

module tb_text_console_engine;
    import tce_pkg::*;

    // The unused opcode; the console must answer it without any effect.
    localparam logic [1:0]  OP_NONE        = 2'd3;
    // Longest legal silence: reset clear or form feed sweep with a scroll
    // queued behind it, plus stalls, taken many times over.
    localparam int unsigned WATCHDOG_LIMIT = 20000;
    // Quiet time after the last response before a color change or the verdict.
    localparam int unsigned SETTLE_CYCLES  = 32;
    localparam int unsigned PHASES         = 6;
    localparam int unsigned PHASE_ITEMS    = 290;

    logic                    clk;
    logic                    rst_n;
    logic                    req_valid;
    logic                    req_stall;
    req_t                    req;
    logic                    rsp_valid;
    logic                    rsp_stall;
    rsp_t                    rsp;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [3:0]              cfg_data;
    int                      fail_count;
    int                      pending;

    // Traffic shaping (no_idle shared by the request and response sides) and the watchdog count.
    bit                      no_idle;
    bit                      stream_text;
    int unsigned             quiet_cycles;

    text_console_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // The checker watches every channel, predicts the console and compares.
    text_console_engine_checker console_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Watchdog: any handshake on any channel counts as progress. A hang in the
    // sweep, the scroll or the response path shows up here.
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Response side: before each response hold stall for a random number of
    // cycles, then drop it and wait for the handshake. Stall also falls on
    // cycles with no response pending, so every phase of the back end sees it.
    initial
    begin
        int unsigned hold;
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            hold = no_idle ? 0 : $urandom_range(0, 9);
            if (hold == 0)
                rsp_stall <= 1'b0;
            else
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(negedge clk);
                rsp_stall <= 1'b0;
            end
            do @(posedge clk); while (!(rsp_valid && !rsp_stall));
        end
    end

    function automatic req_t make_req(logic [1:0] op, logic [7:0] ch, logic [10:0] idx,
                                      logic [4:0] row, logic [6:0] col);
        req_t r;
        r.op         = op;
        r.char_code  = ch;
        r.cell_index = idx;
        r.new_row    = row;
        r.new_col    = col;
        return r;
    endfunction

    // Byte for a put request. Streamed text is mostly printable with line
    // breaks, which drives the cursor to the bottom and forces scrolls; the
    // ordinary mix covers every control code and stray bytes.
    function automatic logic [7:0] pick_byte(bit streaming);
        int unsigned w;
        w = $urandom_range(0, 99);
        if (streaming)
        begin
            if (w < 84)       return 8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
            else if (w < 96)  return CH_NEWLINE;
            else if (w < 98)  return CH_TAB;
            else              return CH_RETURN;
        end
        if (w < 70)       return 8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
        else if (w < 78)  return CH_NEWLINE;
        else if (w < 83)  return CH_TAB;
        else if (w < 88)  return CH_BACKSPACE;
        else if (w < 92)  return CH_RETURN;
        else if (w < 95)  return CH_VTAB;
        else if (w < 96)  return CH_FORMFEED;
        else              return 8'($urandom_range(0, 255));
    endfunction

    // Random request: unused fields carry random bits, the used field is shaped.
    function automatic req_t random_req();
        req_t        r;
        int unsigned sel;
        r = make_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                     11'($urandom_range(0, 2047)), 5'($urandom_range(0, 31)),
                     7'($urandom_range(0, 127)));
        sel = $urandom_range(0, 99);
        if (stream_text)
        begin
            if (sel < 92)
            begin
                r.op        = OP_PUT;
                r.char_code = pick_byte(1'b1);
            end
            else
            begin
                r.op         = OP_READ;
                r.cell_index = 11'($urandom_range(0, 1999));
            end
            return r;
        end
        if (sel < 60)
        begin
            r.op        = OP_PUT;
            r.char_code = pick_byte(1'b0);
        end
        else if (sel < 80)
        begin
            // mostly cells on screen, some past the end of the store
            r.op = OP_READ;
            if ($urandom_range(0, 9) < 7)
                r.cell_index = 11'($urandom_range(0, 1999));
        end
        else if (sel < 93)
        begin
            // mostly legal positions, some that must saturate
            r.op = OP_SETCUR;
            if ($urandom_range(0, 3) != 0)
            begin
                r.new_row = 5'($urandom_range(0, 24));
                r.new_col = 7'($urandom_range(0, 79));
            end
        end
        else
            r.op = OP_NONE;
        return r;
    endfunction

    // Present one request after a random gap and hold it until it is taken.
    // With no gap, valid stays high straight into the next request.
    task automatic issue_request(req_t r);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        @(negedge clk);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        do @(posedge clk); while (!(req_valid && !req_stall));
    endtask

    // Drop valid and wait until every outstanding request has answered,
    // then let the back end come to rest before going on.
    task automatic settle_console();
        @(negedge clk);
        req_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_color(logic [CFG_INDEX_W-1:0] idx, logic [3:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [3:0] fg;
        logic [3:0] bg;
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req         = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        no_idle     = 1'b0;
        stream_text = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        // the store clears itself after reset; wait until requests are taken
        do @(negedge clk); while (req_stall);

        // Directed: reset contents, read bounds, printable bounds, ignored
        // bytes, every control code, cursor saturation, wrap and scroll.
        issue_request(make_req(OP_READ, 8'h00, 11'd0, 5'd0, 7'd0));
        issue_request(make_req(OP_READ, 8'hFF, 11'd1999, 5'd0, 7'd0));
        issue_request(make_req(OP_READ, 8'h00, 11'd2000, 5'd0, 7'd0));
        issue_request(make_req(OP_READ, 8'hFF, 11'h7FF, 5'h1F, 7'h7F));
        issue_request(make_req(OP_PUT, "A", 11'd0, 5'd0, 7'd0));
        issue_request(make_req(OP_PUT, CH_PRINT_LO, 11'd0, 5'd0, 7'd0));
        issue_request(make_req(OP_PUT, CH_PRINT_HI, 11'h7FF, 5'h1F, 7'h7F));
        // just outside the printable range, and the byte extremes: all ignored
        issue_request(make_req(OP_PUT, 8'd31, 11'd0, 5'd0, 7'd0));
        issue_request(make_req(OP_PUT, 8'd127, 11'd0, 5'd0, 7'd0));
        issue_request(make_req(OP_PUT, 8'hFF, 11'd0, 5'd0, 7'd0));
        issue_request(make_req(OP_PUT, 8'h00, 11'd0, 5'd0, 7'd0));
        issue_request(make_req(OP_PUT, CH_TAB, 11'd0, 5'd0, 7'd0));
        issue_request(make_req(OP_PUT, CH_BACKSPACE, 11'd0, 5'd0, 7'd0));
        issue_request(make_req(OP_PUT, CH_RETURN, 11'd0, 5'd0, 7'd0));
        // backspace at column 0 must not move
        issue_request(make_req(OP_PUT, CH_BACKSPACE, 11'd0, 5'd0, 7'd0));
        issue_request(make_req(OP_PUT, CH_VTAB, 11'd0, 5'd0, 7'd0));
        issue_request(make_req(OP_PUT, CH_NEWLINE, 11'd0, 5'd0, 7'd0));
        issue_request(make_req(OP_READ, 8'h00, 11'd80, 5'd0, 7'd0));
        // out-of-range cursor saturates to the bottom right cell
        issue_request(make_req(OP_SETCUR, 8'h00, 11'd0, 5'h1F, 7'h7F));
        // printing in the last cell wraps past the last row and scrolls
        issue_request(make_req(OP_PUT, "Z", 11'd0, 5'd0, 7'd0));
        issue_request(make_req(OP_READ, 8'h00, 11'd1999, 5'd0, 7'd0));
        // tab past the right edge wraps and scrolls again
        issue_request(make_req(OP_SETCUR, 8'h00, 11'd0, 5'd24, 7'd76));
        issue_request(make_req(OP_PUT, CH_TAB, 11'd0, 5'd0, 7'd0));
        issue_request(make_req(OP_PUT, CH_NEWLINE, 11'd0, 5'd0, 7'd0));
        issue_request(make_req(OP_PUT, CH_FORMFEED, 11'd0, 5'd0, 7'd0));
        issue_request(make_req(OP_NONE, 8'hFF, 11'h7FF, 5'h1F, 7'h7F));
        issue_request(make_req(OP_SETCUR, 8'h00, 11'd0, 5'd0, 7'd0));

        // Random phases, each behind a full drain and a color change. The
        // first four settings hit the color extremes; one phase runs without
        // any idling, two stream text to push the cursor into scrolls.
        for (int p = 0; p < PHASES; p++)
        begin
            settle_console();
            fg = (p == 0 || p == 2) ? 4'hF : (p == 1 || p == 3) ? 4'h0
               : 4'($urandom_range(0, 15));
            bg = (p == 1 || p == 2) ? 4'hF : (p == 0 || p == 3) ? 4'h0
               : 4'($urandom_range(0, 15));
            write_color(CFG_TEXT_COLOR, fg);
            write_color(CFG_BACK_COLOR, bg);
            no_idle     = (p == 3);
            stream_text = (p == 2 || p == 5);
            repeat (PHASE_ITEMS) issue_request(random_req());
        end

        settle_console();
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/tce_pkg.sv
sv/tce_ram.sv
sv/tce_front.sv
sv/tce_queue.sv
sv/tce_back.sv
sv/text_console_engine.sv
sv/tce_checker.sv
dv/text_console_engine_checker.sv
dv/tb_text_console_engine.sv
